[hw/rtl/atapio_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package atapio_pkg;

    localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_MODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATAPI_MODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_TOTAL   = 3'd4;

    localparam logic [1:0] MODE_NON_DATA = 2'd0;
    localparam logic [1:0] MODE_PIO_IN   = 2'd1;
    localparam logic [1:0] MODE_PIO_OUT  = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [1:0] FN_START  = 2'd0;
    localparam logic [1:0] FN_IRQ    = 2'd1;
    localparam logic [1:0] FN_STATUS = 2'd2;
    localparam logic [1:0] FN_BLOCK  = 2'd3;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_IRQ    = 2'd1;
    localparam logic [1:0] PH_STATUS = 2'd2;
    localparam logic [1:0] PH_XFER   = 2'd3;

    localparam logic [2:0] ACT_WAIT_IRQ    = 3'd0;
    localparam logic [2:0] ACT_READ_STATUS = 3'd1;
    localparam logic [2:0] ACT_TRANSFER    = 3'd2;
    localparam logic [2:0] ACT_DONE        = 3'd3;
    localparam logic [2:0] ACT_FAILED      = 3'd4;
    localparam logic [2:0] ACT_IGNORED     = 3'd5;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_STATUS  = 2'd2;

    localparam int unsigned ST_BSY_BIT = 7;
    localparam int unsigned ST_DRQ_BIT = 3;

    localparam logic [12:0] BLOCK_BYTES_RST = 13'd512;
    localparam logic [15:0] BLOCK_TOTAL_RST = 16'd1;

    typedef struct packed {
        logic [1:0]  protocol_mode;
        logic        poll_mode;
        logic        atapi_mode;
        logic [12:0] block_bytes;
        logic [15:0] block_total;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] blk_count;
        logic [31:0] bytes_done;
        logic [15:0] packet_bytes;
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  status_byte;
        logic        irq_timed_out;
        logic [15:0] device_byte_count;
    } t_event;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  error_code;
        logic [15:0] block_index;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/atapio_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module atapio_step #(
    parameter int unsigned MAX_BLOCK_BYTES = atapio_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  var atapio_pkg::t_cfg    i_cfg,
    input  var atapio_pkg::t_state  i_state,
    input  var atapio_pkg::t_event  i_event,
    output atapio_pkg::t_state      o_state,
    output atapio_pkg::t_result     o_result
);

    logic        clamp;
    logic [12:0] inc;
    logic [15:0] blocks_inc;
    logic [32:0] bytes_sum;
    logic [31:0] bytes_inc;
    logic        bsy;
    logic        drq;
    logic        write_done;
    logic        read_done;
    atapio_pkg::t_state n_state;
    logic [2:0]  action;
    logic [1:0]  err;

    assign clamp = {19'd0, i_cfg.block_bytes} > 32'(MAX_BLOCK_BYTES);
    assign inc   = clamp ? 13'(MAX_BLOCK_BYTES) : i_cfg.block_bytes;

    assign blocks_inc = (i_state.blk_count != 16'hFFFF) ? i_state.blk_count + 16'd1
                                                        : i_state.blk_count;
    assign bytes_sum  = {1'b0, i_state.bytes_done} + {20'd0, inc};
    assign bytes_inc  = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];

    assign bsy = i_event.status_byte[atapio_pkg::ST_BSY_BIT];
    assign drq = i_event.status_byte[atapio_pkg::ST_DRQ_BIT];

    assign write_done = i_cfg.atapi_mode
        ? (i_state.bytes_done >= {16'd0, i_state.packet_bytes})
        : (i_state.blk_count == i_cfg.block_total);
    assign read_done = i_cfg.atapi_mode
        ? (bytes_inc >= {16'd0, i_state.packet_bytes})
        : (blocks_inc >= i_cfg.block_total);

    always_comb begin
        n_state = i_state;
        action  = atapio_pkg::ACT_IGNORED;
        err     = atapio_pkg::ERR_NONE;
        case (i_event.func)
            atapio_pkg::FN_START: begin
                n_state.blk_count    = '0;
                n_state.bytes_done   = '0;
                n_state.packet_bytes = '0;
                if (i_cfg.protocol_mode == atapio_pkg::MODE_RESERVED) begin
                    n_state.phase = atapio_pkg::PH_IDLE;
                end else if (i_cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT
                             || i_cfg.poll_mode) begin
                    n_state.phase = atapio_pkg::PH_STATUS;
                    action        = atapio_pkg::ACT_READ_STATUS;
                end else begin
                    n_state.phase = atapio_pkg::PH_IRQ;
                    action        = atapio_pkg::ACT_WAIT_IRQ;
                end
            end
            atapio_pkg::FN_IRQ: begin
                if (i_state.phase == atapio_pkg::PH_IRQ) begin
                    if (i_event.irq_timed_out) begin
                        n_state.phase = atapio_pkg::PH_IDLE;
                        action        = atapio_pkg::ACT_FAILED;
                        err           = atapio_pkg::ERR_TIMEOUT;
                    end else begin
                        if (i_cfg.protocol_mode != atapio_pkg::MODE_NON_DATA
                            && i_cfg.atapi_mode && i_state.packet_bytes == 16'd0) begin
                            n_state.packet_bytes = i_event.device_byte_count;
                        end
                        n_state.phase = atapio_pkg::PH_STATUS;
                        action        = atapio_pkg::ACT_READ_STATUS;
                    end
                end
            end
            atapio_pkg::FN_STATUS: begin
                if (i_state.phase == atapio_pkg::PH_STATUS) begin
                    if (i_cfg.protocol_mode == atapio_pkg::MODE_NON_DATA) begin
                        if (bsy) begin
                            action = atapio_pkg::ACT_READ_STATUS;
                        end else begin
                            n_state.phase = atapio_pkg::PH_IDLE;
                            action        = atapio_pkg::ACT_DONE;
                        end
                    end else if (i_cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT
                                 && write_done) begin
                        n_state.phase = atapio_pkg::PH_IDLE;
                        action        = atapio_pkg::ACT_DONE;
                    end else if (!bsy && !drq) begin
                        n_state.phase = atapio_pkg::PH_IDLE;
                        action        = atapio_pkg::ACT_FAILED;
                        err           = atapio_pkg::ERR_STATUS;
                    end else if (bsy) begin
                        action = atapio_pkg::ACT_READ_STATUS;
                    end else begin
                        n_state.phase = atapio_pkg::PH_XFER;
                        action        = atapio_pkg::ACT_TRANSFER;
                    end
                end
            end
            default: begin
                if (i_state.phase == atapio_pkg::PH_XFER) begin
                    n_state.blk_count  = blocks_inc;
                    n_state.bytes_done = bytes_inc;
                    if (i_cfg.protocol_mode != atapio_pkg::MODE_PIO_OUT && read_done) begin
                        n_state.phase = atapio_pkg::PH_IDLE;
                        action        = atapio_pkg::ACT_DONE;
                    end else if (i_cfg.poll_mode) begin
                        n_state.phase = atapio_pkg::PH_STATUS;
                        action        = atapio_pkg::ACT_READ_STATUS;
                    end else begin
                        n_state.phase = atapio_pkg::PH_IRQ;
                        action        = atapio_pkg::ACT_WAIT_IRQ;
                    end
                end
            end
        endcase
    end

    assign o_state              = n_state;
    assign o_result.action      = action;
    assign o_result.error_code  = err;
    assign o_result.block_index = n_state.blk_count;

endmodule

`default_nettype wire

[hw/rtl/ata_pio_protocol_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Host-side sequencer for the data phase of an ATA command.
// Events arrive on the input channel (i_in_valid / o_in_ready): start, interrupt,
// status sample or block moved. Each accepted event yields exactly one result on
// the output channel (o_out_valid / i_out_ready): next action, error code and
// block index.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and writes
// one register per transfer; it is meant to be used only while the block is idle.
// The result of an accepted event is registered in the output register, or in the
// skid register while the receiver stalls. The block takes one event per cycle while
// o_in_ready is high, since the state update ahead of the output stage is combinational.
// A two-entry output stage (output register plus skid register) lets the block
// take an event while a result waits; o_in_ready drops only when both entries are
// full, so a stalled receiver holds back at most two results.
// Synchronous reset returns the configuration to its defaults (non-data mode,
// interrupt driven, 512-byte blocks, one block), the phase to idle, the counters
// to zero and empties the output stage.

module ata_pio_protocol_engine_core #(
    parameter int unsigned MAX_BLOCK_BYTES = atapio_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [atapio_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [atapio_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [1:0]                           i_func,
    input  wire  [7:0]                           i_status_byte,
    input  wire                                  i_irq_timed_out,
    input  wire  [15:0]                          i_device_byte_count,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [2:0]                           o_action,
    output logic [1:0]                           o_error_code,
    output logic [15:0]                          o_block_index
);

    atapio_pkg::t_cfg    r_cfg;
    atapio_pkg::t_state  r_state;
    atapio_pkg::t_state  n_state;
    atapio_pkg::t_event  event_in;
    atapio_pkg::t_result step_result;
    atapio_pkg::t_result r_out;
    atapio_pkg::t_result r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                in_xfer;
    logic                out_xfer;
    logic                cfg_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;

    assign event_in.func              = i_func;
    assign event_in.status_byte       = i_status_byte;
    assign event_in.irq_timed_out     = i_irq_timed_out;
    assign event_in.device_byte_count = i_device_byte_count;

    atapio_step #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_event  (event_in),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol_mode <= atapio_pkg::MODE_NON_DATA;
            r_cfg.poll_mode     <= 1'b0;
            r_cfg.atapi_mode    <= 1'b0;
            r_cfg.block_bytes   <= atapio_pkg::BLOCK_BYTES_RST;
            r_cfg.block_total   <= atapio_pkg::BLOCK_TOTAL_RST;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                atapio_pkg::CFG_PROTOCOL_MODE: r_cfg.protocol_mode <= i_cfg_wdata[1:0];
                atapio_pkg::CFG_POLL_MODE:     r_cfg.poll_mode     <= i_cfg_wdata[0];
                atapio_pkg::CFG_ATAPI_MODE:    r_cfg.atapi_mode    <= i_cfg_wdata[0];
                atapio_pkg::CFG_BLOCK_BYTES:   r_cfg.block_bytes   <= i_cfg_wdata[12:0];
                atapio_pkg::CFG_BLOCK_TOTAL:   r_cfg.block_total   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= atapio_pkg::PH_IDLE;
            r_state.blk_count    <= '0;
            r_state.bytes_done   <= '0;
            r_state.packet_bytes <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_xfer) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_xfer && r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end
            if (in_xfer || r_skid_valid) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid <= step_result;
            end else begin
                r_out <= step_result;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out.action;
    assign o_error_code  = r_out.error_code;
    assign o_block_index = r_out.block_index;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry holds a result while the output register is empty.");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("An accepted event did not produce a result.");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("A result arriving during a stall was not kept in the skid entry.");

    a_failed_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == atapio_pkg::ACT_FAILED))
            |-> (r_out.error_code != atapio_pkg::ERR_NONE))
        else $error("A failed action carries no error code.");

    a_error_only_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_code != atapio_pkg::ERR_NONE))
            |-> (r_out.action == atapio_pkg::ACT_FAILED))
        else $error("An error code appears with an action other than failed.");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_ata_pio_protocol_engine_core.sv]
`timescale 1ns / 1ps

module tb_ata_pio_protocol_engine_core;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned PRINT_LIMIT  = 40;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [atapio_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [atapio_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [1:0]                         i_func;
    logic [7:0]                         i_status_byte;
    logic                               i_irq_timed_out;
    logic [15:0]                        i_device_byte_count;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [2:0]                         o_action;
    logic [1:0]                         o_error_code;
    logic [15:0]                        o_block_index;

    atapio_pkg::t_cfg cfg;
    logic [1:0]       seq_phase;
    logic [15:0]      blk_count;
    logic [31:0]      bytes_done;
    logic [15:0]      pkt_len;

    atapio_pkg::t_result pending_actions[$];
    int unsigned         mismatch_count = 0;
    int unsigned         items_sent = 0;
    int unsigned         cycle_count = 0;
    logic                quiet = 1'b0;

    ata_pio_protocol_engine_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_status_byte      (i_status_byte),
        .i_irq_timed_out    (i_irq_timed_out),
        .i_device_byte_count(i_device_byte_count),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_action           (o_action),
        .o_error_code       (o_error_code),
        .o_block_index      (o_block_index)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 25);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    function automatic logic [2:0] wait_for_next_block();
        if (cfg.poll_mode) begin
            seq_phase = atapio_pkg::PH_STATUS;
            return atapio_pkg::ACT_READ_STATUS;
        end
        seq_phase = atapio_pkg::PH_IRQ;
        return atapio_pkg::ACT_WAIT_IRQ;
    endfunction

    function automatic atapio_pkg::t_result next_action(input logic [1:0] fn,
                                                        input logic [7:0] st,
                                                        input logic tmo,
                                                        input logic [15:0] cnt);
        atapio_pkg::t_result r;
        logic [31:0]         step;
        r.action = atapio_pkg::ACT_IGNORED;
        r.error_code = atapio_pkg::ERR_NONE;
        case (fn)
            atapio_pkg::FN_START: begin
                blk_count = 16'd0;
                bytes_done = 32'd0;
                pkt_len = 16'd0;
                if (cfg.protocol_mode == atapio_pkg::MODE_RESERVED) begin
                    seq_phase = atapio_pkg::PH_IDLE;
                end else if (cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT
                             || cfg.poll_mode) begin
                    seq_phase = atapio_pkg::PH_STATUS;
                    r.action = atapio_pkg::ACT_READ_STATUS;
                end else begin
                    seq_phase = atapio_pkg::PH_IRQ;
                    r.action = atapio_pkg::ACT_WAIT_IRQ;
                end
            end
            atapio_pkg::FN_IRQ: begin
                if (seq_phase == atapio_pkg::PH_IRQ) begin
                    if (tmo) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_FAILED;
                        r.error_code = atapio_pkg::ERR_TIMEOUT;
                    end else begin
                        if (cfg.protocol_mode != atapio_pkg::MODE_NON_DATA && cfg.atapi_mode
                            && pkt_len == 16'd0) begin
                            pkt_len = cnt;
                        end
                        seq_phase = atapio_pkg::PH_STATUS;
                        r.action = atapio_pkg::ACT_READ_STATUS;
                    end
                end
            end
            atapio_pkg::FN_STATUS: begin
                if (seq_phase == atapio_pkg::PH_STATUS) begin
                    if (cfg.protocol_mode == atapio_pkg::MODE_NON_DATA) begin
                        if (st[atapio_pkg::ST_BSY_BIT]) begin
                            r.action = atapio_pkg::ACT_READ_STATUS;
                        end else begin
                            seq_phase = atapio_pkg::PH_IDLE;
                            r.action = atapio_pkg::ACT_DONE;
                        end
                    end else if (cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT
                                 && cfg.atapi_mode
                                 && bytes_done >= {16'd0, pkt_len}) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_DONE;
                    end else if (cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT
                                 && !cfg.atapi_mode
                                 && blk_count == cfg.block_total) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_DONE;
                    end else if (!st[atapio_pkg::ST_BSY_BIT]
                                 && !st[atapio_pkg::ST_DRQ_BIT]) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_FAILED;
                        r.error_code = atapio_pkg::ERR_STATUS;
                    end else if (st[atapio_pkg::ST_BSY_BIT]) begin
                        r.action = atapio_pkg::ACT_READ_STATUS;
                    end else begin
                        seq_phase = atapio_pkg::PH_XFER;
                        r.action = atapio_pkg::ACT_TRANSFER;
                    end
                end
            end
            default: begin
                if (seq_phase == atapio_pkg::PH_XFER) begin
                    step = 32'((cfg.block_bytes > atapio_pkg::MAX_BLOCK_BYTES_DEF)
                               ? atapio_pkg::MAX_BLOCK_BYTES_DEF : cfg.block_bytes);
                    if (blk_count != 16'hFFFF) begin
                        blk_count = blk_count + 16'd1;
                    end
                    if (bytes_done > 32'hFFFF_FFFF - step) begin
                        bytes_done = 32'hFFFF_FFFF;
                    end else begin
                        bytes_done = bytes_done + step;
                    end
                    if (cfg.protocol_mode == atapio_pkg::MODE_PIO_OUT) begin
                        r.action = wait_for_next_block();
                    end else if (!cfg.atapi_mode && blk_count >= cfg.block_total) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_DONE;
                    end else if (cfg.atapi_mode && bytes_done >= {16'd0, pkt_len}) begin
                        seq_phase = atapio_pkg::PH_IDLE;
                        r.action = atapio_pkg::ACT_DONE;
                    end else begin
                        r.action = wait_for_next_block();
                    end
                end
            end
        endcase
        r.block_index = blk_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        atapio_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_actions.size() == 0) begin
                report_mismatch($sformatf("result with no event pending, action %0d", o_action));
            end else begin
                want = pending_actions.pop_front();
                if (o_action !== want.action) begin
                    report_mismatch($sformatf("action %0d, expected %0d", o_action,
                                              want.action));
                end
                if (o_error_code !== want.error_code) begin
                    report_mismatch($sformatf("error_code %0d, expected %0d", o_error_code,
                                              want.error_code));
                end
                if (o_block_index !== want.block_index) begin
                    report_mismatch($sformatf("block_index %0d, expected %0d", o_block_index,
                                              want.block_index));
                end
            end
        end
    end

    task automatic post_event(input logic [1:0] fn, input logic [7:0] st,
                              input logic tmo, input logic [15:0] cnt);
        atapio_pkg::t_result r;
        while (!quiet && $urandom_range(99) < 25) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_status_byte <= st;
        i_irq_timed_out <= tmo;
        i_device_byte_count <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        r = next_action(fn, st, tmo, cnt);
        pending_actions.push_back(r);
        if (r.action != atapio_pkg::ACT_IGNORED) begin
            items_sent++;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_actions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [atapio_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [atapio_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            atapio_pkg::CFG_PROTOCOL_MODE: cfg.protocol_mode = data[1:0];
            atapio_pkg::CFG_POLL_MODE:     cfg.poll_mode = data[0];
            atapio_pkg::CFG_ATAPI_MODE:    cfg.atapi_mode = data[0];
            atapio_pkg::CFG_BLOCK_BYTES:   cfg.block_bytes = data[12:0];
            atapio_pkg::CFG_BLOCK_TOTAL:   cfg.block_total = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_transfer(input logic [1:0] pm, input logic poll, input logic atapi,
                                    input logic [12:0] bb, input logic [15:0] total);
        write_register(atapio_pkg::CFG_PROTOCOL_MODE, {14'd0, pm});
        write_register(atapio_pkg::CFG_POLL_MODE, {15'd0, poll});
        write_register(atapio_pkg::CFG_ATAPI_MODE, {15'd0, atapi});
        write_register(atapio_pkg::CFG_BLOCK_BYTES, {3'd0, bb});
        write_register(atapio_pkg::CFG_BLOCK_TOTAL, total);
    endtask

    task automatic test_non_data();
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'hFF, 1'b0, 16'hFFFF);
        post_event(atapio_pkg::FN_STATUS, 8'h80, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h7F, 1'b1, 16'hFFFF);
        post_event(atapio_pkg::FN_START, 8'hFF, 1'b1, 16'hFFFF);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b1, 16'h1234);
    endtask

    task automatic test_pio_in();
        program_transfer(atapio_pkg::MODE_PIO_IN, 1'b0, 1'b0, 13'd4096, 16'd1);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b0, 16'h0200);
        post_event(atapio_pkg::FN_STATUS, 8'h88, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
    endtask

    task automatic test_pio_out();
        program_transfer(atapio_pkg::MODE_PIO_OUT, 1'b1, 1'b0, 13'd2, 16'd1);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h77, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h00, 1'b0, 16'h0000);
    endtask

    task automatic test_atapi();
        program_transfer(atapio_pkg::MODE_PIO_IN, 1'b0, 1'b1, 13'd8191, 16'd0);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b0, 16'd5000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b0, 16'hFFFF);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
        program_transfer(atapio_pkg::MODE_PIO_OUT, 1'b1, 1'b1, 13'd512, 16'd4);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
    endtask

    task automatic test_restart_and_mode_change();
        program_transfer(atapio_pkg::MODE_PIO_IN, 1'b0, 1'b0, 13'd2, 16'd2);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_IRQ, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_STATUS, 8'h08, 1'b0, 16'h0000);
        write_register(atapio_pkg::CFG_PROTOCOL_MODE, {14'd0, atapio_pkg::MODE_RESERVED});
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_START, 8'h00, 1'b0, 16'h0000);
        post_event(atapio_pkg::FN_BLOCK, 8'h00, 1'b0, 16'h0000);
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned steps;
        int unsigned pick;
        int unsigned eff;
        logic [1:0]  fn;
        logic [7:0]  st;
        logic        tmo;
        logic [15:0] cnt;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            quiet = (items_sent - first >= 300) && (items_sent - first < 500);
            if ($urandom_range(99) < 30) begin
                pick = $urandom_range(99);
                write_register(atapio_pkg::CFG_PROTOCOL_MODE,
                               {14'd0, pick < 20 ? atapio_pkg::MODE_NON_DATA :
                                       pick < 55 ? atapio_pkg::MODE_PIO_IN :
                                       pick < 92 ? atapio_pkg::MODE_PIO_OUT :
                                                   atapio_pkg::MODE_RESERVED});
                write_register(atapio_pkg::CFG_POLL_MODE, 16'($urandom_range(1)));
                write_register(atapio_pkg::CFG_ATAPI_MODE, 16'($urandom_range(1)));
                pick = $urandom_range(99);
                write_register(atapio_pkg::CFG_BLOCK_BYTES,
                               16'(pick < 8 ? 2 : pick < 16 ? 4096 :
                                   pick < 22 ? $urandom_range(8191, 4097) :
                                   $urandom_range(64, 2)));
                pick = $urandom_range(99);
                write_register(atapio_pkg::CFG_BLOCK_TOTAL,
                               16'(pick < 10 ? 0 : pick < 20 ? 16'hFFFF :
                                   pick < 25 ? $urandom_range(65535) :
                                   $urandom_range(5, 1)));
            end
            st = 8'($urandom);
            tmo = 1'($urandom);
            cnt = 16'($urandom);
            post_event(atapio_pkg::FN_START, st, tmo, cnt);
            steps = 0;
            while (seq_phase != atapio_pkg::PH_IDLE && steps < 60) begin
                steps++;
                eff = (cfg.block_bytes > atapio_pkg::MAX_BLOCK_BYTES_DEF)
                      ? atapio_pkg::MAX_BLOCK_BYTES_DEF : cfg.block_bytes;
                st = 8'($urandom);
                cnt = 16'($urandom);
                tmo = ($urandom_range(99) < 6);
                fn = (seq_phase == atapio_pkg::PH_IRQ) ? atapio_pkg::FN_IRQ :
                     (seq_phase == atapio_pkg::PH_STATUS) ? atapio_pkg::FN_STATUS :
                                                            atapio_pkg::FN_BLOCK;
                if (fn == atapio_pkg::FN_IRQ && $urandom_range(99) < 60) begin
                    cnt = 16'(eff * $urandom_range(4, 1) - $urandom_range(1));
                end
                if (fn == atapio_pkg::FN_STATUS) begin
                    pick = $urandom_range(99);
                    if (pick < 20) begin
                        st[atapio_pkg::ST_BSY_BIT] = 1'b1;
                    end else if (pick < 85) begin
                        st[atapio_pkg::ST_BSY_BIT] = 1'b0;
                        st[atapio_pkg::ST_DRQ_BIT] = 1'b1;
                    end else if (pick < 92) begin
                        st[atapio_pkg::ST_BSY_BIT] = 1'b0;
                        st[atapio_pkg::ST_DRQ_BIT] = 1'b0;
                    end
                end
                pick = $urandom_range(99);
                if (pick < 6) begin
                    fn = 2'($urandom);
                    tmo = 1'($urandom);
                end else if (pick < 9) begin
                    write_register(atapio_pkg::CFG_PROTOCOL_MODE, 16'($urandom_range(3)));
                end
                post_event(fn, st, tmo, cnt);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = atapio_pkg::CFG_PROTOCOL_MODE;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_func = atapio_pkg::FN_START;
        i_status_byte = 8'h00;
        i_irq_timed_out = 1'b0;
        i_device_byte_count = 16'h0000;
        i_out_ready = 1'b1;
        cfg.protocol_mode = atapio_pkg::MODE_NON_DATA;
        cfg.poll_mode = 1'b0;
        cfg.atapi_mode = 1'b0;
        cfg.block_bytes = atapio_pkg::BLOCK_BYTES_RST;
        cfg.block_total = atapio_pkg::BLOCK_TOTAL_RST;
        seq_phase = atapio_pkg::PH_IDLE;
        blk_count = 16'd0;
        bytes_done = 32'd0;
        pkt_len = 16'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_non_data();
        test_pio_in();
        test_pio_out();
        test_atapi();
        test_restart_and_mode_change();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
